/* design/sst_pkg.sv */
// Package of shared constants, types and controller encodings for the sorted score table.
`default_nettype none

package sst_pkg;

    // Table depth and the widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed transaction field widths.
    localparam int SCORE_W = 32;
    localparam int NAME_W  = 64;
    localparam int RIDX_W  = 6;
    localparam int RANK_W  = 7;
    localparam int TOTAL_W = 7;

    // Command codes carried by the input transaction.
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [NAME_W-1:0]         name;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PUT,
        S_RD_WAIT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_sub;
        logic accept_rd;
        logic step;
        logic put;
        logic rd_res;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic greater;
        logic i_is_one;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/sst_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface sst_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [sst_pkg::SCORE_W-1:0]  score;
    logic [sst_pkg::NAME_W-1:0]          name_tag;
    logic [sst_pkg::RIDX_W-1:0]          read_index;

    modport source (output valid, output cmd, output score, output name_tag,
                    output read_index, input ready);
    modport sink   (input valid, input cmd, input score, input name_tag,
                    input read_index, output ready);
endinterface

interface sst_out_if;
    logic                                valid;
    logic                                ready;
    logic [sst_pkg::RANK_W-1:0]          rank;
    logic                                stored;
    logic signed [sst_pkg::SCORE_W-1:0]  entry_score;
    logic [sst_pkg::NAME_W-1:0]          entry_name;
    logic                                entry_valid;
    logic [sst_pkg::TOTAL_W-1:0]         entry_total;

    modport source (output valid, output rank, output stored, output entry_score,
                    output entry_name, output entry_valid, output entry_total,
                    input ready);
    modport sink   (input valid, input rank, input stored, input entry_score,
                    input entry_name, input entry_valid, input entry_total,
                    output ready);
endinterface

`default_nettype wire

/* design/sst_ctrl.sv */
// Controller state machine that sequences submit and read transactions.
`default_nettype none

module sst_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_cmd,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    input  wire sst_pkg::t_dp_status i_status,
    output sst_pkg::t_dp_cmd         o_cmd
);

    sst_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sst_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sst_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == sst_pkg::CMD_READ) begin
                        o_cmd.accept_rd = 1'b1;
                        n_state         = sst_pkg::S_RD_WAIT;
                    end else begin
                        o_cmd.accept_sub = 1'b1;
                        n_state = i_status.cnt_zero ? sst_pkg::S_PUT : sst_pkg::S_CMP;
                    end
                end
            end
            sst_pkg::S_CMP: begin
                if (i_status.greater) begin
                    o_cmd.step = 1'b1;
                    if (i_status.i_is_one) begin
                        n_state = sst_pkg::S_PUT;
                    end
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = sst_pkg::S_DONE;
                end
            end
            sst_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = sst_pkg::S_DONE;
            end
            sst_pkg::S_RD_WAIT: begin
                o_cmd.rd_res = 1'b1;
                n_state      = sst_pkg::S_DONE;
            end
            sst_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/sst_dp.sv */
// Datapath: entry memory, insertion walk registers, result and output registers.
`default_nettype none

module sst_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sst_pkg::t_dp_cmd                   i_cmd,
    output sst_pkg::t_dp_status                     o_status,
    input  wire logic signed [sst_pkg::SCORE_W-1:0] i_score,
    input  wire logic [sst_pkg::NAME_W-1:0]         i_name_tag,
    input  wire logic [sst_pkg::RIDX_W-1:0]         i_read_index,
    output logic [sst_pkg::RANK_W-1:0]              o_rank,
    output logic                                    o_stored,
    output logic signed [sst_pkg::SCORE_W-1:0]      o_entry_score,
    output logic [sst_pkg::NAME_W-1:0]              o_entry_name,
    output logic                                    o_entry_valid,
    output logic [sst_pkg::TOTAL_W-1:0]             o_entry_total
);

    localparam int CNT_W  = sst_pkg::CNT_W;
    localparam int IDX_W  = sst_pkg::IDX_W;
    localparam int CMP_W  = sst_pkg::CNT_W + sst_pkg::RIDX_W;

    sst_pkg::t_entry r_mem [sst_pkg::CAPACITY];

    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_i;
    sst_pkg::t_entry       r_new;
    sst_pkg::t_entry       r_rd_data;
    logic                  r_rd_ok;

    logic [sst_pkg::RANK_W-1:0]           r_res_rank;
    logic                                 r_res_stored;
    logic signed [sst_pkg::SCORE_W-1:0]   r_res_score;
    logic [sst_pkg::NAME_W-1:0]           r_res_name;
    logic                                 r_res_valid;
    logic [sst_pkg::TOTAL_W-1:0]          r_res_total;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    sst_pkg::t_entry   wr_data;
    logic              i_in_range;
    logic              full;
    logic              rd_in_range;

    assign full        = (r_count == CNT_W'(sst_pkg::CAPACITY));
    assign i_in_range  = (r_i != CNT_W'(sst_pkg::CAPACITY));
    assign rd_in_range = (CMP_W'(i_read_index) < CMP_W'(r_count));

    assign o_status.cnt_zero = (r_count == '0);
    assign o_status.greater  = (r_new.score > r_rd_data.score);
    assign o_status.i_is_one = (r_i == CNT_W'(1));

    // The read port leads the walk by one entry so a compare happens every cycle.
    always_comb begin
        priority if (i_cmd.accept_rd) begin
            rd_addr = IDX_W'(i_read_index);
        end else if (i_cmd.accept_sub) begin
            rd_addr = IDX_W'(r_count - CNT_W'(1));
        end else begin
            rd_addr = IDX_W'(r_i - CNT_W'(2));
        end
    end

    // Position CAPACITY is a virtual slot past the end; writes there are dropped.
    assign wr_en   = (i_cmd.step || i_cmd.put) && i_in_range;
    assign wr_data = i_cmd.step ? r_rd_data : r_new;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[IDX_W'(r_i)] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.put && i_in_range && !full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_sub) begin
            r_new.score <= i_score;
            r_new.name  <= i_name_tag;
            r_i         <= r_count;
        end else if (i_cmd.step) begin
            r_i <= r_i - CNT_W'(1);
        end
        if (i_cmd.accept_rd) begin
            r_rd_ok <= rd_in_range;
        end
        if (i_cmd.put) begin
            r_res_rank   <= sst_pkg::RANK_W'(r_i) + sst_pkg::RANK_W'(1);
            r_res_stored <= i_in_range;
            r_res_score  <= '0;
            r_res_name   <= '0;
            r_res_valid  <= 1'b0;
            r_res_total  <= sst_pkg::TOTAL_W'(n_count);
        end else if (i_cmd.rd_res) begin
            r_res_rank   <= '0;
            r_res_stored <= 1'b0;
            r_res_score  <= r_rd_ok ? r_rd_data.score : '0;
            r_res_name   <= r_rd_ok ? r_rd_data.name : '0;
            r_res_valid  <= r_rd_ok;
            r_res_total  <= sst_pkg::TOTAL_W'(r_count);
        end
        if (i_cmd.out_load) begin
            o_rank        <= r_res_rank;
            o_stored      <= r_res_stored;
            o_entry_score <= r_res_score;
            o_entry_name  <= r_res_name;
            o_entry_valid <= r_res_valid;
            o_entry_total <= r_res_total;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(sst_pkg::CAPACITY))
        else $error("entry count exceeds table capacity");

    a_count_only_on_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.put |=> $stable(r_count))
        else $error("entry count changed outside an insertion");

    a_step_above_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_i != '0)
        else $error("shift step issued at the head of the table");

endmodule

`default_nettype wire

/* design/sorted_score_table.sv */
// Top level of the sorted score table: channel wiring of controller and datapath.
//
//  Channel   Direction  Modport  Payload
//  i_in      input      sink     cmd, score, name_tag, read_index
//  o_out     output     source   rank, stored, entry_score, entry_name, entry_valid,
//                                entry_total
//
// A read is accepted in S_IDLE, where the memory is read; the result is formed in S_RD_WAIT
// and loaded into the output register in S_DONE, after which the next one can be accepted.
// A submit transaction walks the table from its tail toward the head, one entry per cycle,
// through the single write and single read port of the entry memory; its walk takes one step
// for each of the k stored entries with a strictly lower score (at most CAPACITY), and its
// result is then formed and loaded into the output register in S_DONE.
// Reset is synchronous and active low and leaves the table empty; the memory is not cleared.
// A new transaction is accepted once the previous one has reached the output register, even
// while that result is still stalled; a stalled result holds the next one back.
`default_nettype none

module sorted_score_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sst_in_if.sink    i_in,
    sst_out_if.source o_out
);

    sst_pkg::t_dp_cmd    dp_cmd;
    sst_pkg::t_dp_status dp_status;

    // The controller owns the handshakes and the sequence of the insertion walk.
    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the entries, the entry count and the result registers.
    sst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_score       (i_in.score),
        .i_name_tag    (i_in.name_tag),
        .i_read_index  (i_in.read_index),
        .o_rank        (o_out.rank),
        .o_stored      (o_out.stored),
        .o_entry_score (o_out.entry_score),
        .o_entry_name  (o_out.entry_name),
        .o_entry_valid (o_out.entry_valid),
        .o_entry_total (o_out.entry_total)
    );

endmodule

`default_nettype wire
